// ===== design/json_string_unescape_utf8_defines.svh =====
// Assertion helpers used by json_string_unescape_utf8.sv.
`ifndef JSON_STRING_UNESCAPE_UTF8_DEFINES_SVH
`define JSON_STRING_UNESCAPE_UTF8_DEFINES_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define JSU_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("jsu: implication check failed");

// Next-cycle implication, checked on every clock edge outside reset.
`define JSU_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("jsu: next-cycle check failed");

`endif

// ===== design/jsu_pkg.sv =====
package jsu_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned StatusW = 3;
  localparam int unsigned MaxRes  = 3;

  // Decoder modes.
  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_STR  = 2'd1;
  localparam logic [1:0] MODE_ESC  = 2'd2;
  localparam logic [1:0] MODE_HEX  = 2'd3;

  // Result status codes.
  localparam logic [StatusW-1:0] ST_BYTE   = 3'd0;
  localparam logic [StatusW-1:0] ST_CLOSED = 3'd1;
  localparam logic [StatusW-1:0] ST_ESCTR  = 3'd2;
  localparam logic [StatusW-1:0] ST_UTR    = 3'd3;
  localparam logic [StatusW-1:0] ST_BADHEX = 3'd4;
  localparam logic [StatusW-1:0] ST_UNKESC = 3'd5;
  localparam logic [StatusW-1:0] ST_UNTERM = 3'd6;

  // Characters with a meaning in the string syntax.
  localparam logic [ByteW-1:0] CH_QUOTE = 8'h22;
  localparam logic [ByteW-1:0] CH_BSL   = 8'h5C;
  localparam logic [ByteW-1:0] CH_SLASH = 8'h2F;
  localparam logic [ByteW-1:0] CH_B     = 8'h62;
  localparam logic [ByteW-1:0] CH_F     = 8'h66;
  localparam logic [ByteW-1:0] CH_N     = 8'h6E;
  localparam logic [ByteW-1:0] CH_R     = 8'h72;
  localparam logic [ByteW-1:0] CH_T     = 8'h74;
  localparam logic [ByteW-1:0] CH_U     = 8'h75;

  localparam logic [ByteW-1:0] CTRL_BS  = 8'h08;
  localparam logic [ByteW-1:0] CTRL_FF  = 8'h0C;
  localparam logic [ByteW-1:0] CTRL_LF  = 8'h0A;
  localparam logic [ByteW-1:0] CTRL_CR  = 8'h0D;
  localparam logic [ByteW-1:0] CTRL_TAB = 8'h09;

  // UTF-8 framing bits.
  localparam logic [ByteW-1:0] UTF8_CONT  = 8'h80;
  localparam logic [ByteW-1:0] UTF8_LEAD2 = 8'hC0;
  localparam logic [ByteW-1:0] UTF8_LEAD3 = 8'hE0;

  typedef struct packed {
    logic [ByteW-1:0]   data;
    logic [StatusW-1:0] status;
  } res_t;

endpackage

// ===== design/jsu_in_if.sv =====
interface jsu_in_if import jsu_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] in_byte;
  logic             text_end;

  modport source (output valid, output in_byte, output text_end, input ready);
  modport sink (input valid, input in_byte, input text_end, output ready);
endinterface

// ===== design/jsu_out_if.sv =====
interface jsu_out_if import jsu_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ByteW-1:0]   out_byte;
  logic [StatusW-1:0] status;
  logic               last;

  modport source (output valid, output out_byte, output status, output last, input ready);
  modport sink (input valid, input out_byte, input status, input last, output ready);
endinterface

// ===== design/json_string_unescape_utf8.sv =====
// JSON string unescaper: takes the raw bytes of one quoted string on din, one byte per
// transaction, and delivers decoded bytes, the close, or an error code on dout. An input
// transaction is taken every cycle as long as each produces at most one result and dout
// is ready; the last hex digit of a \u escape yields up to three UTF-8 bytes, which
// leave the result register one per cycle while dout is ready, so din stalls behind
// them. Each byte passes through the input register and then the result register.
// The decoder returns to idle after every close or error; the next byte is then taken as
// a new opening quote.
`include "json_string_unescape_utf8_defines.svh"

module json_string_unescape_utf8
  import jsu_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  jsu_in_if.sink    din,
  jsu_out_if.source dout
);

  // Input register.
  logic             s1_valid;
  logic [ByteW-1:0] s1_byte;
  logic             s1_end;

  // Decoder state.
  logic [1:0]  mode;
  logic [1:0]  hex_count;
  logic [15:0] code_point;
  logic        bad_seen;

  logic [1:0]  mode_next;
  logic [1:0]  hex_count_next;
  logic [15:0] code_point_next;
  logic        bad_seen_next;

  // Result register: slot 0 is on dout, rem results are left.
  res_t       slot [MaxRes];
  logic [1:0] rem;

  res_t       r [MaxRes];
  logic [1:0] n;
  logic       hex_ok;
  logic [3:0] digit;
  logic [15:0] cp_shift;

  logic buf_free;
  logic load;
  logic in_ready;
  logic out_fire;

  assign out_fire = dout.valid && dout.ready;
  assign buf_free = (rem == 2'd0) || ((rem == 2'd1) && dout.ready);
  assign load     = s1_valid && buf_free;
  assign in_ready = !s1_valid || load;
  assign din.ready = in_ready;

  always_comb begin
    hex_ok = 1'b1;
    digit  = 4'd0;
    if (s1_byte inside {[8'h30:8'h39]}) begin
      digit = s1_byte[3:0];
    end else if (s1_byte inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
      digit = s1_byte[3:0] + 4'd9;
    end else begin
      hex_ok = 1'b0;
    end
    cp_shift = {code_point[11:0], digit};
  end

  always_comb begin
    mode_next       = mode;
    hex_count_next  = hex_count;
    code_point_next = code_point;
    bad_seen_next   = bad_seen;
    n = 2'd0;
    for (int i = 0; i < MaxRes; i++) begin
      r[i] = '{data: '0, status: ST_BYTE};
    end

    case (mode)
      MODE_IDLE: begin
        if (!s1_end) begin
          mode_next = MODE_STR;
        end
      end
      MODE_STR: begin
        if (s1_end) begin
          r[0].status = ST_UNTERM;
          n = 2'd1;
          mode_next = MODE_IDLE;
        end else if (s1_byte == CH_QUOTE) begin
          r[0].status = ST_CLOSED;
          n = 2'd1;
          mode_next = MODE_IDLE;
        end else if (s1_byte == CH_BSL) begin
          mode_next = MODE_ESC;
        end else begin
          r[0].data = s1_byte;
          n = 2'd1;
        end
      end
      MODE_ESC: begin
        if (s1_end) begin
          r[0].status = ST_ESCTR;
          n = 2'd1;
          mode_next = MODE_IDLE;
        end else begin
          mode_next = MODE_STR;
          n = 2'd1;
          case (s1_byte)
            CH_QUOTE: r[0].data = CH_QUOTE;
            CH_BSL:   r[0].data = CH_BSL;
            CH_SLASH: r[0].data = CH_SLASH;
            CH_B:     r[0].data = CTRL_BS;
            CH_F:     r[0].data = CTRL_FF;
            CH_N:     r[0].data = CTRL_LF;
            CH_R:     r[0].data = CTRL_CR;
            CH_T:     r[0].data = CTRL_TAB;
            CH_U: begin
              n = 2'd0;
              mode_next = MODE_HEX;
            end
            default: begin
              r[0].status = ST_UNKESC;
              mode_next = MODE_IDLE;
            end
          endcase
        end
      end
      default: begin
        if (s1_end) begin
          r[0].status = ST_UTR;
          n = 2'd1;
          mode_next = MODE_IDLE;
        end else if (hex_count == 2'd3) begin
          // Fourth digit: report a bad digit or emit the code point as UTF-8.
          if (bad_seen || !hex_ok) begin
            r[0].status = ST_BADHEX;
            n = 2'd1;
            mode_next = MODE_IDLE;
          end else begin
            mode_next = MODE_STR;
            if (cp_shift[15:7] == '0) begin
              r[0].data = {1'b0, cp_shift[6:0]};
              n = 2'd1;
            end else if (cp_shift[15:11] == '0) begin
              r[0].data = UTF8_LEAD2 | {3'b000, cp_shift[10:6]};
              r[1].data = UTF8_CONT | {2'b00, cp_shift[5:0]};
              n = 2'd2;
            end else begin
              r[0].data = UTF8_LEAD3 | {4'b0000, cp_shift[15:12]};
              r[1].data = UTF8_CONT | {2'b00, cp_shift[11:6]};
              r[2].data = UTF8_CONT | {2'b00, cp_shift[5:0]};
              n = 2'd3;
            end
          end
        end else begin
          hex_count_next  = hex_count + 2'd1;
          code_point_next = cp_shift;
          bad_seen_next   = bad_seen || !hex_ok;
        end
      end
    endcase

    // Every way out of a \u escape, and every return to idle, clears the digit state.
    if (mode_next != MODE_HEX) begin
      hex_count_next  = 2'd0;
      code_point_next = 16'd0;
      bad_seen_next   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (din.valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (load) begin
      s1_valid <= 1'b0;
    end
    if (din.valid && in_ready) begin
      s1_byte <= din.in_byte;
      s1_end  <= din.text_end;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_IDLE;
      hex_count  <= 2'd0;
      code_point <= 16'd0;
      bad_seen   <= 1'b0;
    end else if (load) begin
      mode       <= mode_next;
      hex_count  <= hex_count_next;
      code_point <= code_point_next;
      bad_seen   <= bad_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= 2'd0;
    end else if (load) begin
      rem <= n;
    end else if (out_fire) begin
      rem <= rem - 2'd1;
    end
    if (load) begin
      for (int i = 0; i < MaxRes; i++) begin
        slot[i] <= r[i];
      end
    end else if (out_fire) begin
      slot[0] <= slot[1];
      slot[1] <= slot[2];
    end
  end

  assign dout.valid    = (rem != 2'd0);
  assign dout.out_byte = slot[0].data;
  assign dout.status   = slot[0].status;
  assign dout.last     = (rem == 2'd1);

  `JSU_ASSERT_IMPL(a_event_is_single, dout.valid && (dout.status != ST_BYTE), dout.last)
  `JSU_ASSERT_IMPL(a_event_no_data, dout.valid && (dout.status != ST_BYTE), dout.out_byte == '0)
  `JSU_ASSERT_IMPL(a_idle_clean, mode != MODE_HEX, (hex_count == 2'd0) && (code_point == 16'd0) && !bad_seen)
  `JSU_ASSERT_NEXT(a_open_silent, load && (mode == MODE_IDLE), rem == 2'd0)

endmodule
